// File: rtl/grq_pkg.sv
`timescale 1ns / 1ps

package grq_pkg;

  localparam int NODES_DEFAULT = 16;

  localparam int ROW_INDEX_W = 4;
  localparam int ROW_BITS_W  = 16;
  localparam int NODE_W      = 8;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_REPORT
  } state_t;

endpackage

// File: rtl/graph_reachability_query_core.sv
`timescale 1ns / 1ps

// Directed graph reachability over a NODES by NODES adjacency bit matrix held in a
// single-port memory with one read per cycle. A request with mode 0 loads one row,
// giving no result. A request with mode 1 returns reachable for the named source and
// target: out-of-range nodes give 0 through the report state without a search; an
// in-range query searches from the source, expanding one node per cycle by reading its
// row from the memory and folding it into the visited set, until every node reachable
// from the source (at most NODES) is expanded. in_ready is low from an accepted query
// until its result is loaded into the output register. Rows read as zero until written;
// reset clears them at once through per-row valid bits.
module graph_reachability_query_core
  import grq_pkg::*;
#(
  parameter int NODES = NODES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    mode,
  input  logic [ROW_INDEX_W-1:0]  row_index,
  input  logic [ROW_BITS_W-1:0]   row_bits,
  input  logic signed [NODE_W-1:0] source_node,
  input  logic signed [NODE_W-1:0] target_node,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    reachable
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

  function automatic logic [AW-1:0] encode_onehot(input logic [NODES-1:0] oh);
    logic [AW-1:0] idx;
    idx = '0;
    for (int i = 0; i < NODES; i++) begin
      if (oh[i]) idx = idx | AW'(i);
    end
    return idx;
  endfunction

  state_t state, state_next;

  logic [NODES-1:0] mem [NODES];
  logic [NODES-1:0] row_valid;
  logic [NODES-1:0] rdata;
  logic             rdata_ok;

  logic [NODES-1:0] visited, visited_next;
  logic [NODES-1:0] expanded, expanded_next;
  logic             rd_pend, rd_pend_next;
  logic [AW-1:0]    tgt, tgt_next;
  logic             same, same_next;
  logic             result, result_next;
  logic             out_valid_next, reachable_next;

  logic             accept;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [NODES-1:0] wr_row;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             src_ok, dst_ok;
  logic [AW-1:0]    src_idx, dst_idx;
  logic [NODES-1:0] vis_now, pend, pick;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign wr_en   = accept && (mode == MODE_WRITE) && (int'(row_index) < NODES);
  assign wr_addr = AW'(row_index);
  assign wr_row  = NODES'(row_bits);

  assign src_ok  = !source_node[NODE_W-1] && (int'(source_node) < NODES);
  assign dst_ok  = !target_node[NODE_W-1] && (int'(target_node) < NODES);
  assign src_idx = AW'($unsigned(source_node));
  assign dst_idx = AW'($unsigned(target_node));

  assign vis_now = visited | ((rd_pend && rdata_ok) ? rdata : '0);
  assign pend    = vis_now & ~expanded;
  assign pick    = pend & (~pend + NODES'(1));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata    <= mem[rd_addr];
      rdata_ok <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    visited   <= visited_next;
    expanded  <= expanded_next;
    tgt       <= tgt_next;
    same      <= same_next;
    result    <= result_next;
    reachable <= reachable_next;
  end

  always_comb begin
    state_next     = state;
    visited_next   = visited;
    expanded_next  = expanded;
    rd_pend_next   = rd_pend;
    tgt_next       = tgt;
    same_next      = same;
    result_next    = result;
    out_valid_next = out_valid && !out_ready;
    reachable_next = reachable;
    rd_en          = 1'b0;
    rd_addr        = encode_onehot(pick);
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_QUERY)) begin
          if (src_ok && dst_ok) begin
            visited_next  = NODES'(1) << src_idx;
            expanded_next = '0;
            rd_pend_next  = 1'b0;
            tgt_next      = dst_idx;
            same_next     = (src_idx == dst_idx);
            state_next    = ST_SEARCH;
          end else begin
            result_next = 1'b0;
            state_next  = ST_REPORT;
          end
        end
      end
      ST_SEARCH: begin
        visited_next = vis_now;
        if (pend != '0) begin
          rd_en         = 1'b1;
          expanded_next = expanded | pick;
          rd_pend_next  = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
          result_next  = same || vis_now[tgt];
          state_next   = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          reachable_next = result;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_expanded_visited: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> ((expanded & ~visited) == '0))
    else $error("expanded node not in visited set");

  a_read_in_search: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ST_SEARCH))
    else $error("row read outstanding outside search");

  a_bad_node_false: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_QUERY) && !(src_ok && dst_ok))
      |=> (state == ST_REPORT) && !result)
    else $error("out-of-range query not reported as unreachable");

  a_search_start: assert property (@(posedge clk) disable iff (rst)
    (accept && (mode == MODE_QUERY) && src_ok && dst_ok)
      |=> (state == ST_SEARCH) && (expanded == '0) && $onehot(visited))
    else $error("search did not start from the source alone");

endmodule
